// ===== rtl/lms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LCD mode and line sequencer package
// Shared widths, timing constants, mode codes and the structs that pass
// configuration, sequencer state and per-tick results between modules.
// ---------------------------------------------------------------------------
package lms_pkg;

    // Field widths.
    localparam int DOT_W   = 9;
    localparam int LINE_W  = 8;
    localparam int IRQEN_W = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Line timing.
    localparam logic [DOT_W-1:0]  DOTS_PER_LINE = 9'd456;
    localparam logic [DOT_W-1:0]  SCAN_DOTS     = 9'd80;
    localparam logic [DOT_W-1:0]  DOT_MAX       = 9'd511;
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STAT_IRQ_EN  = 2'd1;

    // Bits of the STAT interrupt enable register.
    localparam int IRQEN_HBLANK = 0;
    localparam int IRQEN_VBLANK = 1;
    localparam int IRQEN_MATCH  = 2;

    typedef enum logic [1:0] {
        MODE_LINE_IDLE  = 2'd0,
        MODE_FRAME_IDLE = 2'd1,
        MODE_SCAN       = 2'd2,
        MODE_PIXEL      = 2'd3
    } lms_mode_t;

    typedef struct packed {
        logic [LINE_W-1:0]  line_compare;
        logic [IRQEN_W-1:0] stat_irq_enables;
    } lms_cfg_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot_count;
        logic [LINE_W-1:0] current_line;
        lms_mode_t         current_mode;
        logic              match_flag;
    } lms_state_t;

    // Packed so that the last field lands in the lowest bits of tdata.
    typedef struct packed {
        logic              frame_done;
        logic              end_transfer;
        logic              start_transfer;
        logic              stat_irq;
        logic              vblank_irq;
        logic              line_match;
        logic [LINE_W-1:0] line;
        lms_mode_t         mode;
    } lms_result_t;

endpackage : lms_pkg
`default_nettype wire

// ===== rtl/lms_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LCD mode and line sequencer configuration registers
// Holds the line compare value and the STAT interrupt enables.
// ---------------------------------------------------------------------------
module lms_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_write,
    input  wire logic [lms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lms_pkg::lms_cfg_t                   cfg
);
    import lms_pkg::*;

    lms_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_LINE_COMPARE: begin
                    cfg_reg.line_compare <= cfg_data[LINE_W-1:0];
                end
                REG_STAT_IRQ_EN: begin
                    cfg_reg.stat_irq_enables <= cfg_data[IRQEN_W-1:0];
                end
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : lms_cfg
`default_nettype wire

// ===== rtl/lms_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LCD mode and line sequencer tick logic
// Computes the next sequencer state and the result of one dot tick.
// ---------------------------------------------------------------------------
module lms_step (
    input  wire lms_pkg::lms_state_t state,
    input  wire lms_pkg::lms_cfg_t   cfg,
    input  wire logic                transfer_done,
    output lms_pkg::lms_state_t      state_next,
    output lms_pkg::lms_result_t     result
);
    import lms_pkg::*;

    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W-1:0] line_inc;
    logic              line_hit;
    logic              vbl;
    logic              stat;
    logic              start;
    logic              finish;
    logic              frame;

    // The dot counter advances first and saturates when a transfer hangs.
    assign dot_inc  = (state.dot_count < DOT_MAX) ? state.dot_count + DOT_W'(1)
                                                  : state.dot_count;
    assign line_inc = state.current_line + LINE_W'(1);
    assign line_hit = (line_inc == cfg.line_compare);

    always_comb begin
        state_next           = state;
        state_next.dot_count = dot_inc;
        vbl    = 1'b0;
        stat   = 1'b0;
        start  = 1'b0;
        finish = 1'b0;
        frame  = 1'b0;

        case (state.current_mode)
            MODE_SCAN: begin
                if (dot_inc >= SCAN_DOTS) begin
                    state_next.current_mode = MODE_PIXEL;
                    start = 1'b1;
                end
            end
            MODE_PIXEL: begin
                if (transfer_done) begin
                    state_next.current_mode = MODE_LINE_IDLE;
                    finish = 1'b1;
                    stat   = cfg.stat_irq_enables[IRQEN_HBLANK];
                end
            end
            MODE_FRAME_IDLE: begin
                if (dot_inc >= DOTS_PER_LINE) begin
                    state_next.current_line = line_inc;
                    state_next.match_flag   = line_hit;
                    state_next.dot_count    = '0;
                    stat = line_hit & cfg.stat_irq_enables[IRQEN_MATCH];
                    // The compare above sees the last line before the wrap.
                    if (line_inc >= TOTAL_LINES) begin
                        state_next.current_mode = MODE_SCAN;
                        state_next.current_line = '0;
                    end
                end
            end
            MODE_LINE_IDLE: begin
                if (dot_inc >= DOTS_PER_LINE) begin
                    state_next.current_line = line_inc;
                    state_next.match_flag   = line_hit;
                    state_next.dot_count    = '0;
                    stat = line_hit & cfg.stat_irq_enables[IRQEN_MATCH];
                    if (line_inc >= VISIBLE_LINES) begin
                        state_next.current_mode = MODE_FRAME_IDLE;
                        vbl   = 1'b1;
                        frame = 1'b1;
                        stat  = stat | cfg.stat_irq_enables[IRQEN_VBLANK];
                    end else begin
                        state_next.current_mode = MODE_SCAN;
                    end
                end
            end
            default: begin
                state_next = state;
            end
        endcase
    end

    always_comb begin
        result.mode           = state_next.current_mode;
        result.line           = state_next.current_line;
        result.line_match     = state_next.match_flag;
        result.vblank_irq     = vbl;
        result.stat_irq       = stat;
        result.start_transfer = start;
        result.end_transfer   = finish;
        result.frame_done     = frame;
    end

endmodule : lms_step
`default_nettype wire

// ===== rtl/lcd_mode_line_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LCD mode and line sequencer
// Tracks dot, line and LCD mode per dot tick and emits mode, line, interrupt
// pulses and pixel pipeline strobes for every tick.
// ---------------------------------------------------------------------------
// Usage:
// Each beat on the s_ channel is one dot clock tick; bit 0 of s_tdata says
// that the pixel pipeline has pushed a full line. Every tick produces exactly
// one beat on the m_ channel with the mode, line and the event pulses of that
// tick. The cfg_ channel writes the line compare value (index 0) and the STAT
// interrupt enables (index 1); it is always ready and should only be used
// while no ticks are in flight.
// A tick lands in the input register, then the mode rule runs on it and its
// result loads the result register. Throughput is one tick per cycle while
// the receiver keeps m_tready high. When the receiver stalls, the result
// register holds its beat and the input register takes one more tick before
// s_tready drops. Reset puts the line at 0 in OAM scan with the dot counter
// cleared, clears both configuration registers and empties both pipeline
// registers.
// ---------------------------------------------------------------------------
module lcd_mode_line_sequencer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Tick input.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata bit 0: transfer_done; bits 7:1 unused.
    input  wire logic [lms_pkg::S_TDATA_W-1:0]   s_tdata,
    // Per-tick result.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata from bit 0: mode[1:0], line[9:2], line_match[10],
    // vblank_irq[11], stat_irq[12], start_transfer[13], end_transfer[14],
    // frame_done[15].
    output logic [lms_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lms_pkg::*;

    lms_cfg_t    cfg;
    lms_state_t  state_reg;
    lms_state_t  state_next;
    lms_result_t result;

    logic        in_valid_reg;
    logic        in_done_reg;
    logic        out_valid_reg;
    lms_result_t out_data_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    lms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lms_step u_step (
        .state         (state_reg),
        .cfg           (cfg),
        .transfer_done (in_done_reg),
        .state_next    (state_next),
        .result        (result)
    );

    // The result register can take a new beat when it is empty or draining.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_done_reg <= s_tdata[0];
        end
    end

    // Sequencer state moves only when a tick is handed to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dot_count    <= '0;
            state_reg.current_line <= '0;
            state_reg.current_mode <= MODE_SCAN;
            state_reg.match_flag   <= 1'b0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : lcd_mode_line_sequencer
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode and line sequencer testbench
// Streams dot ticks into the sequencer and checks every per-tick result beat
// against a cycle-free model of the mode and line timing. The run walks the
// start of a frame under several register settings, with random gaps on
// both sides of the stream.
// ---------------------------------------------------------------------------
module testbench;
    import lms_pkg::*;

    // Register indexes past the two real registers; writes to them must be
    // dropped by the block.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int IDLE_PCT       = 38;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_CAP     = 40;
    localparam int STEADY_TICKS   = 120;
    localparam int DIRECTED_TICKS = 24;
    localparam int PHASE_TICKS    = 200;

    // Tracks dot, line and mode one tick at a time and queues the result
    // beat that each accepted tick must produce.
    class lcd_timing_board;
        logic [DOT_W-1:0]   dots;
        logic [LINE_W-1:0]  line;
        lms_mode_t          mode;
        logic               match;
        logic [LINE_W-1:0]  cmp;
        logic [IRQEN_W-1:0] irq_en;
        lms_result_t        due[$];

        function new();
            dots   = '0;
            line   = '0;
            mode   = MODE_SCAN;
            match  = 1'b0;
            cmp    = '0;
            irq_en = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_LINE_COMPARE) begin
                cmp = value;
            end else if (idx == REG_STAT_IRQ_EN) begin
                irq_en = value[IRQEN_W-1:0];
            end
        endfunction

        // Moves to the next line and refreshes the match flag. Returns 1 when
        // the match raises an enabled STAT event.
        function bit bump_line();
            line = line + 8'd1;
            if (line == cmp) begin
                match = 1'b1;
                return irq_en[IRQEN_MATCH];
            end
            match = 1'b0;
            return 1'b0;
        endfunction

        function void note_tick(bit done);
            lms_result_t r;
            r = '0;
            if (dots < DOT_MAX) dots = dots + 9'd1;
            case (mode)
                MODE_SCAN: begin
                    if (dots >= SCAN_DOTS) begin
                        mode = MODE_PIXEL;
                        r.start_transfer = 1'b1;
                    end
                end
                MODE_PIXEL: begin
                    if (done) begin
                        mode = MODE_LINE_IDLE;
                        r.end_transfer = 1'b1;
                        if (irq_en[IRQEN_HBLANK]) r.stat_irq = 1'b1;
                    end
                end
                MODE_FRAME_IDLE: begin
                    if (dots >= DOTS_PER_LINE) begin
                        if (bump_line()) r.stat_irq = 1'b1;
                        if (line >= TOTAL_LINES) begin
                            mode = MODE_SCAN;
                            line = '0;
                        end
                        dots = '0;
                    end
                end
                default: begin
                    if (dots >= DOTS_PER_LINE) begin
                        if (bump_line()) r.stat_irq = 1'b1;
                        if (line >= VISIBLE_LINES) begin
                            mode = MODE_FRAME_IDLE;
                            r.vblank_irq = 1'b1;
                            r.frame_done = 1'b1;
                            if (irq_en[IRQEN_VBLANK]) r.stat_irq = 1'b1;
                        end else begin
                            mode = MODE_SCAN;
                        end
                        dots = '0;
                    end
                end
            endcase
            r.mode       = mode;
            r.line       = line;
            r.line_match = match;
            due.push_back(r);
        endfunction

        // Returns an empty string when the beat matches the oldest expected
        // result, or else a list of the fields that differ (got/expected).
        function string check_beat(lms_result_t got);
            string       msg;
            lms_result_t want;
            msg = "";
            if (due.size() == 0) return $sformatf(" result beat with no tick waiting, tdata %h", got);
            want = due.pop_front();
            if (got.mode !== want.mode)
                msg = {msg, $sformatf(" mode %0d/%0d", got.mode, want.mode)};
            if (got.line !== want.line)
                msg = {msg, $sformatf(" line %0d/%0d", got.line, want.line)};
            if (got.line_match !== want.line_match)
                msg = {msg, $sformatf(" line_match %b/%b", got.line_match, want.line_match)};
            if (got.vblank_irq !== want.vblank_irq)
                msg = {msg, $sformatf(" vblank_irq %b/%b", got.vblank_irq, want.vblank_irq)};
            if (got.stat_irq !== want.stat_irq)
                msg = {msg, $sformatf(" stat_irq %b/%b", got.stat_irq, want.stat_irq)};
            if (got.start_transfer !== want.start_transfer)
                msg = {msg, $sformatf(" start_transfer %b/%b",
                                      got.start_transfer, want.start_transfer)};
            if (got.end_transfer !== want.end_transfer)
                msg = {msg, $sformatf(" end_transfer %b/%b",
                                      got.end_transfer, want.end_transfer)};
            if (got.frame_done !== want.frame_done)
                msg = {msg, $sformatf(" frame_done %b/%b", got.frame_done, want.frame_done)};
            return msg;
        endfunction

        function int waiting();
            return due.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tdata bit 0: transfer_done; the upper bits are zero padding.
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tdata from bit 0: mode, line, line_match, vblank_irq, stat_irq,
    // start_transfer, end_transfer, frame_done.
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lcd_timing_board board = new();
    int              errors      = 0;
    int              quiet       = 0;
    int              steady_left = 0;
    string           beat_msg;

    lcd_mode_line_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Every mismatch costs one line and one count; printing stops after a
    // while so that a broken block cannot flood the log.
    task automatic report(input string msg);
        errors++;
        if (errors <= REPORT_CAP) $display("mismatch at %0t ns:%s", $time, msg);
    endtask

    // All sampling happens at the rising edge, before the block's own
    // nonblocking updates land, so the values seen are the ones that took
    // part in the handshake. A register write is applied to the model before
    // a tick of the same edge, although the two never overlap in practice.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) board.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready) begin
                beat_msg = board.check_beat(m_tdata);
                if (beat_msg != "") report(beat_msg);
            end
            // The watchdog only counts edges at which no beat of any kind
            // moved, so long runs do not trip it while a hung block does.
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // The receiver stalls at random, except during the steady stretch at the
    // start of the second phase.
    always @(negedge aclk) begin
        m_tready <= (steady_left > 0) || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offers one tick and holds it until it is taken. Entered and left at a
    // falling edge; tvalid stays high so back-to-back ticks need no gap.
    task automatic send_tick(input bit done);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, done};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic idle_tick();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops the tick stream and waits until every expected beat has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.waiting() != 0);
    endtask

    // One register write. The channel is lowered again afterward,
    // so a following write never raises and lowers valid in the same step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // The pixel pipeline's flag is chosen from the model's view of the mode.
    // In transfer it fires now and then, so lines finish well before the line
    // end; on a stuck line it is held off until the dot counter has
    // saturated, which also makes hblank start past the line end. Outside
    // transfer the flag is random noise that the block must ignore.
    function automatic bit pick_done(input bit stuck);
        if (board.mode == MODE_PIXEL) begin
            if (stuck) return (board.dots == DOT_MAX) && ($urandom_range(0, 3) == 0);
            return $urandom_range(0, 15) == 0;
        end
        return $urandom_range(0, 7) == 0;
    endfunction

    task automatic run_ticks(input int count);
        bit                stuck;
        logic [LINE_W-1:0] seen_line;
        stuck     = 1'b0;
        seen_line = board.line;
        for (int k = 0; k < count; k++) begin
            // About one line in twenty gets a transfer that hangs until the dot counter saturates.
            if (board.line != seen_line) begin
                seen_line = board.line;
                stuck     = ($urandom_range(0, 19) == 0);
            end
            if (steady_left > 0) begin
                steady_left--;
            end else begin
                while ($urandom_range(0, 99) < IDLE_PCT) idle_tick();
            end
            send_tick(pick_done(stuck));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed start with the reset register values: back-to-back ticks
        // in OAM scan with the transfer flag both set and clear, where it
        // must have no effect.
        for (int k = 0; k < DIRECTED_TICKS; k++) send_tick(k % 3 != 1);
        run_ticks(150);
        drain();

        // Compare against the line count reached just before the wrap, all
        // enables set through a value that only survives masking, and a write
        // to a register index that does not exist. This phase starts with a
        // long stretch without any stalls.
        write_reg(REG_LINE_COMPARE, TOTAL_LINES);
        write_reg(REG_STAT_IRQ_EN, 8'hFF);
        write_reg(REG_SPARE_LO, 8'h5A);
        steady_left = STEADY_TICKS;
        run_ticks(PHASE_TICKS);
        drain();

        // Compare value on the line that starts vblank, with vblank and
        // match enables.
        write_reg(REG_LINE_COMPARE, VISIBLE_LINES);
        write_reg(REG_STAT_IRQ_EN, 8'h06);
        run_ticks(100);
        drain();

        // Largest compare value and an enable value whose low bits are all
        // clear, plus a write to the other unused index.
        write_reg(REG_LINE_COMPARE, 8'hFF);
        write_reg(REG_STAT_IRQ_EN, 8'hF8);
        write_reg(REG_SPARE_HI, 8'hFF);
        run_ticks(60);
        drain();

        write_reg(REG_LINE_COMPARE, 8'($urandom_range(1, 153)));
        write_reg(REG_STAT_IRQ_EN, 8'($urandom_range(0, 255)));
        run_ticks(70);
        drain();

        // Give the two-stage pipeline time to show any stray beat.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.waiting() != 0)
            report($sformatf(" %0d expected beats never arrived", board.waiting()));
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
